>>> rtl/core/rrdf_pkg.sv
// ----------------------------------------------------------------------------
// rrdf_pkg
// Shared types and constants of the receive record framer.
// ----------------------------------------------------------------------------
package rrdf_pkg;

    localparam int MAX_RECORD  = 32;
    localparam int BUF_SIZE    = MAX_RECORD + 4;
    localparam int STORE_DEPTH = 2 * BUF_SIZE;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int PW          = $clog2(BUF_SIZE + 1);
    localparam int LW          = $clog2(MAX_RECORD + 1);

    // item function codes
    localparam logic [1:0] FN_BYTE  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    // delimiter modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_EXCL = 2'd1;
    localparam logic [1:0] MODE_INCL = 2'd2;

    // register indexes
    localparam logic [2:0] REG_START_MODE = 3'd0;
    localparam logic [2:0] REG_END_MODE   = 3'd1;
    localparam logic [2:0] REG_START_CHAR = 3'd2;
    localparam logic [2:0] REG_END_CHAR   = 3'd3;
    localparam logic [2:0] REG_MAX_LENGTH = 3'd4;
    localparam logic [2:0] REG_PAD_CHAR   = 3'd5;
    localparam logic [2:0] REG_SWAP_GROUP = 3'd6;
    localparam logic [2:0] REG_AUTO_INC   = 3'd7;

    typedef struct packed {
        logic [1:0] func;
        logic       pending;
        logic       pre_close;
        logic       acq1;
        logic       need_gpad;
        logic       gpad_last;
        logic       len_hit;
        logic       tail_set;
        logic       tail_close;
        logic       differs;
        logic       auto_mode;
        logic       swpad_last;
        logic       clr_last;
        logic       out_free;
    } t_status;

    typedef struct packed {
        logic cap;
        logic clr;
        logic head;
        logic gpad;
        logic byte_wr;
        logic set_acq;
        logic close;
        logic swap_host;
        logic conflict;
        logic swpad;
        logic load;
    } t_cmd;

    // True when the group phase sits on a group boundary (phase mod size is 0)
    function automatic logic group_boundary(input logic [2:0] phase,
                                            input logic [1:0] sg);
        logic r;
        begin
            r = 1'b0;
            case (sg)
                2'd0: r = 1'b1;
                2'd1: r = (phase[0] == 1'b0);
                2'd2: r = (phase == 3'd0) || (phase == 3'd3) || (phase == 3'd6);
                default: r = (phase[1:0] == 2'd0);
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/core/rrdf_ctrl.sv
// ----------------------------------------------------------------------------
// rrdf_ctrl
// Sequencer of the record framer: steps one item through its memory writes.
// ----------------------------------------------------------------------------
module rrdf_ctrl import rrdf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_GPAD   = 4'd3;
    localparam logic [3:0] S_BYTE   = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_TAIL   = 4'd6;
    localparam logic [3:0] S_CLOSE  = 4'd7;
    localparam logic [3:0] S_SWPAD  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_status.func)
                    FN_BYTE: begin
                        if (!i_status.pending) begin
                            o_cmd.head = 1'b1;
                            if (i_status.pre_close)      n_state = S_CLOSE;
                            else if (!i_status.acq1)     n_state = S_TAIL;
                            else if (i_status.need_gpad) n_state = S_GPAD;
                            else                         n_state = S_BYTE;
                        end
                    end
                    FN_WRITE: begin
                        if (i_status.differs) begin
                            if (i_status.pending) begin
                                o_cmd.swap_host = 1'b1;
                                n_state         = S_SWPAD;
                            end else begin
                                o_cmd.conflict = 1'b1;
                            end
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_GPAD: begin
                o_cmd.gpad = 1'b1;
                if (i_status.gpad_last) n_state = S_BYTE;
            end
            S_BYTE: begin
                o_cmd.byte_wr = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.len_hit ? S_CLOSE : S_TAIL;
            end
            S_TAIL: begin
                n_state = S_DONE;
                if (i_status.tail_set)        o_cmd.set_acq = 1'b1;
                else if (i_status.tail_close) n_state = S_CLOSE;
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = i_status.auto_mode ? S_SWPAD : S_DONE;
            end
            S_SWPAD: begin
                o_cmd.swpad = 1'b1;
                if (i_status.swpad_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_cmd.load && !o_cmd.swpad)
        else $error("ready while busy");
    a_cap_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap |=> r_state == S_DECODE)
        else $error("capture not followed by decode");
    a_close_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.close && i_status.auto_mode |=> r_state == S_SWPAD)
        else $error("auto close skipped pad fill");

endmodule

>>> rtl/core/rrdf_datapath.sv
// ----------------------------------------------------------------------------
// rrdf_datapath
// Registers, record store and result register of the record framer.
// ----------------------------------------------------------------------------
module rrdf_datapath import rrdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic       i_cfg_valid,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic [1:0] i_func,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_host_record,
    input  logic       i_parity_seen,
    input  logic [5:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_taken,
    output logic       o_record_done,
    output logic       o_refused_write,
    output logic [7:0] o_current_record,
    output logic       o_new_data,
    output logic       o_data_toggle,
    output logic       o_conflict,
    output logic       o_parity_flag,
    output logic [7:0] o_read_data,
    output logic [5:0] o_read_length
);

    // configuration
    logic [1:0] r_start_mode, r_end_mode, r_swap_group;
    logic [7:0] r_start_char, r_end_char, r_pad_char;
    logic [5:0] r_max_length;
    logic       r_auto;

    // framing state
    logic          r_acq;
    logic [2:0]    r_phase;
    logic          r_fsel;
    logic [PW-1:0] r_fp;
    logic [7:0]    r_rec;
    logic          r_new, r_tog, r_conf, r_par;
    logic [LW-1:0] r_len0, r_len1;
    logic [AW-1:0] r_cnt;

    // latched item
    logic [1:0] r_func;
    logic [7:0] r_byte, r_hrec;
    logic       r_ipar;
    logic [5:0] r_ridx;
    logic       r_taken, r_done, r_ref;

    // store
    logic [7:0]    r_mem [STORE_DEPTH];
    logic [7:0]    r_mem_q;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;

    logic          r_ovalid;
    logic [LW-1:0] cur_len, oth_len;
    logic [LW-1:0] limit;
    logic          acq0, case_a;
    logic [2:0]    phase_n;
    logic [PW-1:0] byte_pos;
    logic [AW-1:0] fill_base, oth_base;

    assign cur_len   = r_fsel ? r_len1 : r_len0;
    assign oth_len   = r_fsel ? r_len0 : r_len1;
    assign fill_base = r_fsel ? AW'(BUF_SIZE) : '0;
    assign oth_base  = r_fsel ? '0 : AW'(BUF_SIZE);
    assign phase_n   = r_phase + 3'd1;
    assign byte_pos  = r_fp - PW'(phase_n);
    assign rd_addr   = oth_base + AW'(r_ridx);

    // clamp length limit to 1..MAX_RECORD
    always_comb begin
        if (r_max_length == '0)                  limit = LW'(1);
        else if (r_max_length > 6'(MAX_RECORD)) limit = LW'(MAX_RECORD);
        else                                     limit = LW'(r_max_length);
    end

    // head of a received byte
    assign acq0   = r_acq || (r_start_mode == MODE_NONE);
    assign case_a = !acq0 && (r_start_mode == MODE_INCL) && (r_byte == r_start_char);

    always_comb begin
        o_status            = '0;
        o_status.func       = r_func;
        o_status.pending    = r_new;
        o_status.pre_close  = !case_a && acq0 && (r_end_mode == MODE_EXCL)
                              && (r_byte == r_end_char);
        o_status.acq1       = acq0 || case_a;
        o_status.need_gpad  = group_boundary(r_phase, r_swap_group);
        o_status.gpad_last  = (r_cnt == AW'(r_swap_group));
        o_status.len_hit    = (cur_len >= limit);
        o_status.tail_set   = !r_acq && (r_start_mode == MODE_EXCL)
                              && (r_byte == r_start_char);
        o_status.tail_close = r_acq && (r_end_mode == MODE_INCL) && (r_byte == r_end_char);
        o_status.differs    = (r_hrec != r_rec);
        o_status.auto_mode  = r_auto;
        o_status.swpad_last = (r_cnt == AW'(limit - LW'(1)));
        o_status.clr_last   = (r_cnt == AW'(STORE_DEPTH - 1));
        o_status.out_free   = !r_ovalid || i_out_ready;
    end

    // select the single store write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_pad_char;
        if (i_cmd.clr) begin
            wr_en   = 1'b1;
            wr_addr = r_cnt;
            wr_data = '0;
        end else if (i_cmd.gpad) begin
            wr_en   = (r_fp < PW'(BUF_SIZE));
            wr_addr = fill_base + AW'(r_fp);
        end else if (i_cmd.byte_wr) begin
            wr_en   = (PW'(phase_n) <= r_fp) && (byte_pos < PW'(BUF_SIZE));
            wr_addr = fill_base + AW'(byte_pos);
            wr_data = r_byte;
        end else if (i_cmd.swpad) begin
            wr_en   = 1'b1;
            wr_addr = fill_base + r_cnt;
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_mem_q <= r_mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mode <= MODE_NONE;
            r_end_mode   <= MODE_INCL;
            r_start_char <= 8'd58;
            r_end_char   <= 8'd13;
            r_max_length <= 6'd20;
            r_pad_char   <= 8'd0;
            r_swap_group <= 2'd0;
            r_auto       <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_MODE: r_start_mode <= i_cfg_data[1:0];
                REG_END_MODE:   r_end_mode   <= i_cfg_data[1:0];
                REG_START_CHAR: r_start_char <= i_cfg_data;
                REG_END_CHAR:   r_end_char   <= i_cfg_data;
                REG_MAX_LENGTH: r_max_length <= i_cfg_data[5:0];
                REG_PAD_CHAR:   r_pad_char   <= i_cfg_data;
                REG_SWAP_GROUP: r_swap_group <= i_cfg_data[1:0];
                REG_AUTO_INC:   r_auto       <= i_cfg_data[0];
                default:        r_auto       <= r_auto;
            endcase
        end
    end

    // latch the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func <= i_func;
            r_byte <= i_rx_byte;
            r_hrec <= i_host_record;
            r_ipar <= i_parity_seen;
            r_ridx <= i_read_index;
        end
    end

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acq   <= 1'b0;
            r_phase <= '0;
            r_fsel  <= 1'b0;
            r_fp    <= '0;
            r_rec   <= '0;
            r_new   <= 1'b0;
            r_tog   <= 1'b0;
            r_conf  <= 1'b0;
            r_par   <= 1'b0;
            r_len0  <= '0;
            r_len1  <= '0;
            r_cnt   <= '0;
            r_taken <= 1'b0;
            r_done  <= 1'b0;
            r_ref   <= 1'b0;
        end else begin
            if (i_cmd.clr || i_cmd.gpad || i_cmd.swpad) r_cnt <= r_cnt + AW'(1);
            if (i_cmd.cap) begin
                r_taken <= 1'b0;
                r_done  <= 1'b0;
                r_ref   <= 1'b0;
            end
            // start a byte: take it, open the record, rewind the group
            if (i_cmd.head) begin
                r_taken <= 1'b1;
                r_acq   <= o_status.acq1;
                r_cnt   <= '0;
                if (o_status.need_gpad) r_phase <= '0;
            end
            if (i_cmd.gpad && (r_fp < PW'(BUF_SIZE))) r_fp <= r_fp + PW'(1);
            // advance phase and count the stored byte
            if (i_cmd.byte_wr) begin
                r_phase <= phase_n;
                if (cur_len < LW'(MAX_RECORD)) begin
                    if (r_fsel) r_len1 <= r_len1 + LW'(1);
                    else        r_len0 <= r_len0 + LW'(1);
                end
            end
            if (i_cmd.set_acq) r_acq <= 1'b1;
            if (i_cmd.conflict) begin
                r_conf <= 1'b1;
                r_ref  <= 1'b1;
            end
            // close the record: auto swap or flag the host
            if (i_cmd.close) begin
                r_acq   <= 1'b0;
                r_phase <= '0;
                r_done  <= 1'b1;
                if (r_auto) begin
                    r_fsel <= ~r_fsel;
                    r_fp   <= '0;
                    r_cnt  <= '0;
                    r_rec  <= r_rec + 8'd1;
                    r_par  <= r_ipar;
                    if (r_fsel) r_len0 <= '0;
                    else        r_len1 <= '0;
                end else begin
                    r_new <= 1'b1;
                    r_tog <= ~r_tog;
                end
            end
            // host handshake swap clears the new, toggle, conflict and parity flags
            if (i_cmd.swap_host) begin
                r_fsel <= ~r_fsel;
                r_fp   <= '0;
                r_cnt  <= '0;
                r_rec  <= r_hrec;
                r_new  <= 1'b0;
                r_tog  <= 1'b0;
                r_conf <= 1'b0;
                r_par  <= 1'b0;
                if (r_fsel) r_len0 <= '0;
                else        r_len1 <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_taken          <= r_taken;
            o_record_done    <= r_done;
            o_refused_write  <= r_ref;
            o_current_record <= r_rec;
            o_new_data       <= r_new;
            o_data_toggle    <= r_tog;
            o_conflict       <= r_conf;
            o_parity_flag    <= r_par;
            o_read_data      <= ((r_func == FN_READ) && (r_ridx < 6'(BUF_SIZE)))
                                ? r_mem_q : 8'd0;
            o_read_length    <= (r_func == FN_READ) ? 6'(oth_len) : 6'd0;
        end
    end

    assign o_out_valid = r_ovalid;

    a_fp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fp <= PW'(BUF_SIZE))
        else $error("fill pointer past buffer");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len0 <= LW'(MAX_RECORD)) && (r_len1 <= LW'(MAX_RECORD)))
        else $error("record length past limit");
    a_swap_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.close && r_auto) || i_cmd.swap_host |=> r_fsel != $past(r_fsel))
        else $error("swap did not flip buffers");

endmodule

>>> rtl/core/rx_record_delimiter_framer_unit.sv
// ----------------------------------------------------------------------------
// rx_record_delimiter_framer_unit
// Frames received bytes into double-buffered records with host handshake.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        sink       i_in_valid / o_in_ready    i_func, i_rx_byte, i_host_record,
//                                                  i_parity_seen, i_read_index
//  out       source     o_out_valid / i_out_ready  o_taken .. o_read_length
//  cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  Reads and host writes are the shortest beats; a received byte takes its store
//  writes in turn, and one that opens a group first writes group padding; a record
//  close in auto mode and a host write that swaps also pad the new fill buffer;
//  the single write port of the record store sets these lengths.
//  After reset a clearing pass writes all 72 store entries while o_in_ready
//  stays low; configuration beats are taken at all times.
//  A stalled output holds the finished beat; the next input beat is still taken.
// ----------------------------------------------------------------------------
module rx_record_delimiter_framer_unit import rrdf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_host_record,
    input  logic       i_parity_seen,
    input  logic [5:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_taken,
    output logic       o_record_done,
    output logic       o_refused_write,
    output logic [7:0] o_current_record,
    output logic       o_new_data,
    output logic       o_data_toggle,
    output logic       o_conflict,
    output logic       o_parity_flag,
    output logic [7:0] o_read_data,
    output logic [5:0] o_read_length,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_status status;
    t_cmd    cmd;

    assign o_cfg_ready = 1'b1;

    rrdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rrdf_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_rx_byte        (i_rx_byte),
        .i_host_record    (i_host_record),
        .i_parity_seen    (i_parity_seen),
        .i_read_index     (i_read_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_taken          (o_taken),
        .o_record_done    (o_record_done),
        .o_refused_write  (o_refused_write),
        .o_current_record (o_current_record),
        .o_new_data       (o_new_data),
        .o_data_toggle    (o_data_toggle),
        .o_conflict       (o_conflict),
        .o_parity_flag    (o_parity_flag),
        .o_read_data      (o_read_data),
        .o_read_length    (o_read_length)
    );

endmodule
